/* rtl/core/mandelbrot_escape_time_top_defines.svh */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Shared concurrent assertion forms for the escape-time block.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/met_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Widths, register codes, reset values, command and status types and the
// saturation helper shared by the escape-time modules.
// ----------------------------------------------------------------------------
package met_pkg;

   // Image geometry and fixed-point format.
   localparam int unsigned IMG_WIDTH  = 512;
   localparam int unsigned IMG_HEIGHT = 512;
   localparam int unsigned FRAC_BITS  = 28;

   // Field widths.
   localparam int unsigned PIX_W  = 9;
   localparam int unsigned ZW     = 32;
   localparam int unsigned WIDE_W = 2 * ZW;
   localparam int unsigned CNT_W  = 16;
   localparam int unsigned TOL_W  = 29;
   localparam int unsigned IDX_W  = 3;
   localparam int unsigned DATA_W = 32;

   // Span times pixel: 33-bit signed span by a 10-bit non-negative pixel.
   localparam int unsigned SPAN_W = ZW + 1;
   localparam int unsigned MAP_W  = SPAN_W + PIX_W + 1;

   // Largest power of two that does not exceed n, as an exponent.
   function automatic int unsigned floor_log2(input int unsigned n);
      int unsigned s;
      s = 0;
      while ((s < 31) && ((n >> (s + 1)) != 0)) begin
         s = s + 1;
      end
      return s;
   endfunction

   localparam int unsigned SHIFT_X = floor_log2(IMG_WIDTH);
   localparam int unsigned SHIFT_Y = floor_log2(IMG_HEIGHT);

   // Escape bound 4.0 at double fraction width.
   localparam logic [WIDE_W-1:0] ESCAPE_MAG = WIDE_W'(4) << (2 * FRAC_BITS);

   // Saturation bounds of a z component.
   localparam logic signed [ZW-1:0] ZMAX = {1'b0, {(ZW-1){1'b1}}};
   localparam logic signed [ZW-1:0] ZMIN = {1'b1, {(ZW-1){1'b0}}};

   // Register indexes.
   typedef enum logic [IDX_W-1:0] {
      CSR_REAL_MIN   = 3'd0,
      CSR_REAL_MAX   = 3'd1,
      CSR_IMAG_MIN   = 3'd2,
      CSR_IMAG_MAX   = 3'd3,
      CSR_ITER_LIMIT = 3'd4,
      CSR_TOLERANCE  = 3'd5
   } csr_index_type;

   // Configuration register set.
   typedef struct packed {
      logic signed [ZW-1:0] real_min;
      logic signed [ZW-1:0] real_max;
      logic signed [ZW-1:0] imag_min;
      logic signed [ZW-1:0] imag_max;
      logic [CNT_W-1:0]     iteration_limit;
      logic [TOL_W-1:0]     settle_tolerance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      real_min:         32'sd0,
      real_max:         32'sd134217728,
      imag_min:         -32'sd161061274,
      imag_max:         32'sd0,
      iteration_limit:  16'd1023,
      settle_tolerance: 29'd26844
   };

   // Which value goes into the result count.
   typedef enum logic {
      RES_COUNT = 1'b0,
      RES_LIMIT = 1'b1
   } res_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        map_mul;
      logic        map_add;
      logic        z_update;
      logic        z_square;
      logic        cnt_inc;
      logic        res_load;
      res_sel_type res_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic limit_zero;
      logic escaped;
      logic settled;
      logic last_iter;
   } stat_type;

   // Clamp a wide signed value to the z component range.
   function automatic logic signed [ZW-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
      logic hi_same;
      hi_same = (v[WIDE_W-1:ZW-1] == '0) || (v[WIDE_W-1:ZW-1] == '1);
      if (hi_same) begin
         return v[ZW-1:0];
      end else if (v[WIDE_W-1]) begin
         return ZMIN;
      end else begin
         return ZMAX;
      end
   endfunction

endpackage

/* rtl/core/mandelbrot_escape_time_top.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time top level
// Configuration registers, controller and datapath of the escape-time block.
// ----------------------------------------------------------------------------
// An item is accepted when start is high while busy is low. The result comes
// back on rsp_out_x, rsp_out_y and rsp_escape_count for exactly one cycle,
// marked by rsp_valid; the receiver cannot stall it, so it must capture the
// result in that cycle. The iteration loop alternates two states: SQUARE forms
// the two squares and the cross product of z on three 32x32 multipliers, and
// STEP checks escape and settling and forms the new z. A new item may be
// started in the same cycle as the strobe. Configuration is written through
// csr_we, csr_index and csr_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [met_pkg::PIX_W-1:0]    req_pixel_x,
   input  logic [met_pkg::PIX_W-1:0]    req_pixel_y,
   output logic                         rsp_valid,
   output logic [met_pkg::PIX_W-1:0]    rsp_out_x,
   output logic [met_pkg::PIX_W-1:0]    rsp_out_y,
   output logic [met_pkg::CNT_W-1:0]    rsp_escape_count,
   input  logic                         csr_we,
   input  logic [met_pkg::IDX_W-1:0]    csr_index,
   input  logic [met_pkg::DATA_W-1:0]   csr_wdata
);

   met_pkg::cfg_type  cfg;
   met_pkg::cmd_type  cmd;
   met_pkg::stat_type stat;

   // Configuration registers.
   met_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencing of one item.
   met_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Mapping, iteration and result registers.
   met_datapath u_datapath (
      .clock            (clock),
      .cfg              (cfg),
      .cmd              (cmd),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .stat             (stat),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_escape_count (rsp_escape_count)
   );

endmodule

/* rtl/core/met_csr.sv */
// ----------------------------------------------------------------------------
// Escape-time configuration registers
// Write-only register file holding the complex window, the iteration limit
// and the settle tolerance.
// ----------------------------------------------------------------------------
module met_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [met_pkg::IDX_W-1:0]      csr_index,
   input  logic [met_pkg::DATA_W-1:0]     csr_wdata,
   output met_pkg::cfg_type               cfg
);

   met_pkg::cfg_type cfg_ff;

   // Decode the register index; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= met_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            met_pkg::CSR_REAL_MIN:   cfg_ff.real_min <= signed'(csr_wdata);
            met_pkg::CSR_REAL_MAX:   cfg_ff.real_max <= signed'(csr_wdata);
            met_pkg::CSR_IMAG_MIN:   cfg_ff.imag_min <= signed'(csr_wdata);
            met_pkg::CSR_IMAG_MAX:   cfg_ff.imag_max <= signed'(csr_wdata);
            met_pkg::CSR_ITER_LIMIT: begin
               cfg_ff.iteration_limit <= csr_wdata[met_pkg::CNT_W-1:0];
            end
            met_pkg::CSR_TOLERANCE: begin
               cfg_ff.settle_tolerance <= csr_wdata[met_pkg::TOL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/met_datapath.sv */
// ----------------------------------------------------------------------------
// Escape-time datapath
// Maps the pixel into the complex window, runs the z = z*z + c recurrence
// with three 32x32 multipliers and forms the result item.
// ----------------------------------------------------------------------------
module met_datapath (
   input  logic                         clock,
   input  met_pkg::cfg_type             cfg,
   input  met_pkg::cmd_type             cmd,
   input  logic [met_pkg::PIX_W-1:0]    req_pixel_x,
   input  logic [met_pkg::PIX_W-1:0]    req_pixel_y,
   output met_pkg::stat_type            stat,
   output logic [met_pkg::PIX_W-1:0]    rsp_out_x,
   output logic [met_pkg::PIX_W-1:0]    rsp_out_y,
   output logic [met_pkg::CNT_W-1:0]    rsp_escape_count
);

   localparam int unsigned ZW     = met_pkg::ZW;
   localparam int unsigned WIDE_W = met_pkg::WIDE_W;

   // Captured pixel.
   logic [met_pkg::PIX_W-1:0] px_ff, py_ff;

   // Mapping products and the point c.
   logic signed [met_pkg::SPAN_W-1:0] span_r, span_i;
   logic signed [met_pkg::MAP_W-1:0]  prod_r_in, prod_i_in, prod_r_ff, prod_i_ff;
   logic signed [WIDE_W-1:0]          map_r_sum, map_i_sum;
   logic signed [ZW-1:0]              cr_ff, ci_ff;

   // Orbit state.
   logic signed [ZW-1:0]     zr_ff, zi_ff, zr_old_ff, zi_old_ff;
   logic signed [ZW-1:0]     zr_in, zi_in;
   logic signed [WIDE_W-1:0] xx_ff, yy_ff, xy_ff;
   logic signed [WIDE_W-1:0] xx_in, yy_in, xy_in;
   logic signed [WIDE_W-1:0] re_sum, im_sum;
   logic [WIDE_W-1:0]        mag;

   // Settle test.
   logic signed [ZW:0] dr, di;
   logic [ZW:0]        dr_abs, di_abs, tol_ext;
   logic               settled_in, settled_ff;

   // Iteration count and result.
   logic [met_pkg::CNT_W-1:0] count_ff;
   logic [met_pkg::PIX_W-1:0] out_x_ff, out_y_ff;
   logic [met_pkg::CNT_W-1:0] escape_count_ff;

   // Window spans times pixel index.
   always_comb begin
      span_r    = {cfg.real_max[ZW-1], cfg.real_max} - {cfg.real_min[ZW-1], cfg.real_min};
      span_i    = {cfg.imag_max[ZW-1], cfg.imag_max} - {cfg.imag_min[ZW-1], cfg.imag_min};
      prod_r_in = span_r * $signed({1'b0, px_ff});
      prod_i_in = span_i * $signed({1'b0, py_ff});
   end

   // Scale by the image size and add the lower window edge.
   always_comb begin
      map_r_sum = WIDE_W'(cfg.real_min) + WIDE_W'(prod_r_ff >>> met_pkg::SHIFT_X);
      map_i_sum = WIDE_W'(cfg.imag_min) + WIDE_W'(prod_i_ff >>> met_pkg::SHIFT_Y);
   end

   // Next z from the registered products, saturated to the component range.
   always_comb begin
      re_sum = ((xx_ff - yy_ff) >>> met_pkg::FRAC_BITS) + WIDE_W'(cr_ff);
      im_sum = (xy_ff >>> (met_pkg::FRAC_BITS - 1)) + WIDE_W'(ci_ff);
      zr_in  = met_pkg::sat_z(re_sum);
      zi_in  = met_pkg::sat_z(im_sum);
   end

   // Products of the current z.
   always_comb begin
      xx_in = zr_ff * zr_ff;
      yy_in = zi_ff * zi_ff;
      xy_in = zr_ff * zi_ff;
   end

   // Change of each component over the last step against the tolerance.
   always_comb begin
      dr         = {zr_ff[ZW-1], zr_ff} - {zr_old_ff[ZW-1], zr_old_ff};
      di         = {zi_ff[ZW-1], zi_ff} - {zi_old_ff[ZW-1], zi_old_ff};
      dr_abs     = dr[ZW] ? $unsigned(-dr) : $unsigned(dr);
      di_abs     = di[ZW] ? $unsigned(-di) : $unsigned(di);
      tol_ext    = (ZW + 1)'(cfg.settle_tolerance);
      settled_in = (dr_abs < tol_ext) && (di_abs < tol_ext);
   end

   // Squared magnitude of the current z; both squares are non-negative.
   assign mag = $unsigned(xx_ff) + $unsigned(yy_ff);

   // Status toward the controller.
   always_comb begin
      stat.limit_zero = (cfg.iteration_limit == '0);
      stat.escaped    = (mag > met_pkg::ESCAPE_MAG);
      stat.settled    = settled_ff;
      stat.last_iter  = (count_ff == (cfg.iteration_limit - met_pkg::CNT_W'(1)));
   end

   // Datapath registers, each loaded on its own command.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
      end
      if (cmd.map_mul) begin
         prod_r_ff <= prod_r_in;
         prod_i_ff <= prod_i_in;
      end
      if (cmd.map_add) begin
         cr_ff    <= met_pkg::sat_z(map_r_sum);
         ci_ff    <= met_pkg::sat_z(map_i_sum);
         zr_ff    <= '0;
         zi_ff    <= '0;
         xx_ff    <= '0;
         yy_ff    <= '0;
         xy_ff    <= '0;
         count_ff <= '0;
      end
      if (cmd.z_update) begin
         zr_old_ff <= zr_ff;
         zi_old_ff <= zi_ff;
         zr_ff     <= zr_in;
         zi_ff     <= zi_in;
      end
      if (cmd.z_square) begin
         xx_ff      <= xx_in;
         yy_ff      <= yy_in;
         xy_ff      <= xy_in;
         settled_ff <= settled_in;
      end
      if (cmd.cnt_inc) begin
         count_ff <= count_ff + met_pkg::CNT_W'(1);
      end
      if (cmd.res_load) begin
         out_x_ff        <= px_ff;
         out_y_ff        <= py_ff;
         escape_count_ff <= (cmd.res_sel == met_pkg::RES_LIMIT) ?
                            cfg.iteration_limit : count_ff;
      end
   end

   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_escape_count = escape_count_ff;

endmodule

/* rtl/core/met_ctrl.sv */
// ----------------------------------------------------------------------------
// Escape-time controller
// Sequences mapping, the square-and-update iteration loop and the result
// strobe for one item at a time.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_top_defines.svh"

module met_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  met_pkg::stat_type  stat,
   output met_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);

   typedef enum logic [2:0] {
      IDLE,
      MAP_MUL,
      MAP_ADD,
      FIRST_STEP,
      SQUARE,
      STEP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, done;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      done     = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = MAP_MUL;
            end
         end
         MAP_MUL: begin
            cmd.map_mul = 1'b1;
            state_in    = MAP_ADD;
         end
         MAP_ADD: begin
            cmd.map_add = 1'b1;
            if (stat.limit_zero) begin
               // No step runs; the limit itself is the zero count.
               cmd.res_load = 1'b1;
               cmd.res_sel  = met_pkg::RES_LIMIT;
               done         = 1'b1;
               state_in     = IDLE;
            end else begin
               state_in = FIRST_STEP;
            end
         end
         FIRST_STEP: begin
            cmd.z_update = 1'b1;
            state_in     = SQUARE;
         end
         SQUARE: begin
            cmd.z_square = 1'b1;
            state_in     = STEP;
         end
         STEP: begin
            // Check the step just finished; if the item is not done, start the next one.
            if (stat.escaped) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = met_pkg::RES_COUNT;
               done         = 1'b1;
               state_in     = IDLE;
            end else if (stat.settled || stat.last_iter) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = met_pkg::RES_LIMIT;
               done         = 1'b1;
               state_in     = IDLE;
            end else begin
               cmd.cnt_inc  = 1'b1;
               cmd.z_update = 1'b1;
               state_in     = SQUARE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= done;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The strobe only appears once the controller has returned to idle.
   `MET_ASSERT_SAME(a_strobe_in_idle, clock, reset, rsp_valid_ff, state_ff == IDLE, "result strobe while busy")
   // The strobe lasts a single cycle.
   `MET_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe held over two cycles")
   // An accepted item always starts with the mapping multiply.
   `MET_ASSERT_NEXT(a_start_maps, clock, reset, start && !busy, state_ff == MAP_MUL, "accepted item did not start mapping")
   // The count never advances past the last allowed step.
   `MET_ASSERT_SAME(a_count_bound, clock, reset, cmd.cnt_inc, !stat.last_iter, "iteration count advanced past the limit")

endmodule
